// ===== rtl/core/mdfm_pkg.sv =====
// ----------------------------------------------------------------------------
// mdfm_pkg
// Shared types, widths, register indexes and reset values for the switch
// debounce and fault monitor.
// ----------------------------------------------------------------------------
package mdfm_pkg;

   // Defaults for the top level parameters
   localparam int CHANNELS_DEF  = 10;
   localparam int TIME_BITS_DEF = 32;

   // Fixed field widths
   localparam int PIN_W     = 10;
   localparam int MASK_W    = 10;
   localparam int SETTLE_W  = 8;
   localparam int SPAN_W    = 16;
   localparam int COUNT_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Toggle counter saturation value
   localparam logic [COUNT_W-1:0] TOGGLE_MAX = {COUNT_W{1'b1}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF = 3'd5;

   // Register reset values
   localparam logic [SETTLE_W-1:0] SETTLE_RST  = 8'd1;
   localparam logic [SPAN_W-1:0]   LOCKOUT_RST = 16'd1000;
   localparam logic [SPAN_W-1:0]   STUCK_RST   = 16'd1000;
   localparam logic [SPAN_W-1:0]   WINDOW_RST  = 16'd5000;
   localparam logic [COUNT_W-1:0]  LIMIT_RST   = 4'd10;
   localparam logic [SPAN_W-1:0]   HOLDOFF_RST = 16'd2000;

   // Configuration register set
   typedef struct packed {
      logic [SETTLE_W-1:0] settle;
      logic [SPAN_W-1:0]   lockout;
      logic [SPAN_W-1:0]   stuck;
      logic [SPAN_W-1:0]   window;
      logic [COUNT_W-1:0]  limit;
      logic [SPAN_W-1:0]   holdoff;
   } mdfm_cfg_type;

   // Per-lane status handed to the merge stage
   typedef struct packed {
      logic hit;
      logic healthy;
      logic pressed;
   } mdfm_lane_stat_type;

   // Result item
   typedef struct packed {
      logic [MASK_W-1:0] hit_mask;
      logic [MASK_W-1:0] healthy_mask;
      logic [MASK_W-1:0] pressed_mask;
   } mdfm_rsp_type;

endpackage

// ===== rtl/core/mdfm_channels_if.sv =====
// ----------------------------------------------------------------------------
// mdfm channel interfaces
// Valid/ready channels for the sample input, the result output and the
// register write port.
// ----------------------------------------------------------------------------
interface mdfm_req_if
   import mdfm_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface

interface mdfm_rsp_if
   import mdfm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] hit_mask;
   logic [MASK_W-1:0] healthy_mask;
   logic [MASK_W-1:0] pressed_mask;

   modport source (output valid, output hit_mask, output healthy_mask,
                   output pressed_mask, input ready);
   modport sink   (input valid, input hit_mask, input healthy_mask,
                   input pressed_mask, output ready);
endinterface

interface mdfm_csr_if
   import mdfm_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mdfm_lane.sv =====
// ----------------------------------------------------------------------------
// mdfm_lane
// One switch channel: debounce, press request, stuck-low and chatter fault
// detection, and hit edge reporting.
// ----------------------------------------------------------------------------
module mdfm_lane
   import mdfm_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [TIME_BITS-1:0] tick,
   input  logic                 armed,
   input  mdfm_cfg_type         cfg,
   input  logic                 rd,
   input  logic                 grant,
   output logic                 press_req,
   output mdfm_lane_stat_type   stat
);

   logic                 raw_prev_ff, raw_prev_in;
   logic                 stable_ff, stable_in;
   logic                 rep_ff, rep_in;
   logic                 healthy_ff, healthy_in;
   logic [TIME_BITS-1:0] ltt_ff, ltt_in;
   logic [TIME_BITS-1:0] ws_ff, ws_in;
   logic [TIME_BITS-1:0] pt_ff, pt_in;
   logic [COUNT_W-1:0]   tc_ff, tc_in;

   logic                 toggle, settled, change, rel_c, stuck_hit, in_win;
   logic                 stable1, h1, stable2, hit;
   logic [COUNT_W-1:0]   tc1;
   logic [TIME_BITS-1:0] el_tog, el_pt, el_ws;

   // Raw edge tracking and toggle count
   assign toggle      = (rd != raw_prev_ff) && healthy_ff;
   assign ltt_in      = toggle ? tick : ltt_ff;
   assign raw_prev_in = toggle ? rd : raw_prev_ff;
   assign tc1         = (toggle && (tc_ff != TOGGLE_MAX)) ? tc_ff + 1'b1 : tc_ff;

   // Debounce: level stable longer than the settle time
   assign el_tog    = tick - ltt_in;
   assign settled   = el_tog > {{(TIME_BITS-SETTLE_W){1'b0}}, cfg.settle};
   assign change    = settled && healthy_ff && (rd != stable_ff);
   assign press_req = change && !rd;
   assign rel_c     = change && rd;

   assign stable1 = grant ? 1'b0 : (rel_c ? 1'b1 : stable_ff);
   assign pt_in   = grant ? tick : pt_ff;

   // Stuck-low check (skipped on the step of a fresh grant)
   assign el_pt     = tick - pt_ff;
   assign stuck_hit = !grant && !stable1 && healthy_ff &&
                      (el_pt > {{(TIME_BITS-SPAN_W){1'b0}}, cfg.stuck});
   assign h1        = healthy_ff && !stuck_hit;
   assign stable2   = stuck_hit ? 1'b1 : stable1;

   // Chatter window
   assign el_ws  = tick - ws_ff;
   assign in_win = el_ws < {{(TIME_BITS-SPAN_W){1'b0}}, cfg.window};

   always_comb begin
      healthy_in = h1;
      stable_in  = stable2;
      tc_in      = tc1;
      ws_in      = ws_ff;
      if (h1) begin
         if (in_win) begin
            if (tc1 > cfg.limit) begin
               healthy_in = 1'b0;
               stable_in  = 1'b1;
               tc_in      = '0;
               ws_in      = tick;
            end
         end else begin
            tc_in = '0;
            ws_in = tick;
         end
      end else begin
         tc_in = '0;
      end
   end

   // Hit edge reporting
   always_comb begin
      hit    = 1'b0;
      rep_in = rep_ff;
      if (armed && healthy_in) begin
         if (!stable_in && rep_ff) begin
            hit    = 1'b1;
            rep_in = 1'b0;
         end else if (stable_in && !rep_ff) begin
            rep_in = 1'b1;
         end
      end
   end

   assign stat.hit     = hit;
   assign stat.healthy = healthy_in;
   assign stat.pressed = !stable_in;

   // Lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff <= 1'b1;
         stable_ff   <= 1'b1;
         rep_ff      <= 1'b1;
         healthy_ff  <= 1'b1;
         ltt_ff      <= '0;
         ws_ff       <= '0;
         pt_ff       <= '0;
         tc_ff       <= '0;
      end else if (step) begin
         raw_prev_ff <= raw_prev_in;
         stable_ff   <= stable_in;
         rep_ff      <= rep_in;
         healthy_ff  <= healthy_in;
         ltt_ff      <= ltt_in;
         ws_ff       <= ws_in;
         pt_ff       <= pt_in;
         tc_ff       <= tc_in;
      end
   end

endmodule

// ===== rtl/core/mdfm_merge.sv =====
// ----------------------------------------------------------------------------
// mdfm_merge
// Global press lockout with lowest-channel priority, and assembly of the
// lane status into the result masks.
// ----------------------------------------------------------------------------
module mdfm_merge
   import mdfm_pkg::*;
#(
   parameter int CHANNELS  = CHANNELS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [TIME_BITS-1:0] tick,
   input  logic [SPAN_W-1:0]    lockout,
   input  logic [CHANNELS-1:0]  press_req,
   output logic [CHANNELS-1:0]  grant,
   input  mdfm_lane_stat_type   stat [CHANNELS],
   output mdfm_rsp_type         rsp
);

   logic [TIME_BITS-1:0] last_press_ff, last_press_in;
   logic [TIME_BITS-1:0] el_lock;
   logic                 lock_ok;

   // Only the lowest requesting channel can pass: once one is taken the
   // lockout restarts at this tick
   assign el_lock = tick - last_press_ff;
   assign lock_ok = el_lock > {{(TIME_BITS-SPAN_W){1'b0}}, lockout};
   assign grant   = lock_ok ? (press_req & (~press_req + 1'b1)) : '0;

   assign last_press_in = (|grant) ? tick : last_press_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_press_ff <= '0;
      end else if (step) begin
         last_press_ff <= last_press_in;
      end
   end

   // Mask assembly
   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < CHANNELS) begin : g_used
         assign rsp.hit_mask[j]     = stat[j].hit;
         assign rsp.healthy_mask[j] = stat[j].healthy;
         assign rsp.pressed_mask[j] = stat[j].pressed;
      end else begin : g_unused
         assign rsp.hit_mask[j]     = 1'b0;
         assign rsp.healthy_mask[j] = 1'b0;
         assign rsp.pressed_mask[j] = 1'b0;
      end
   end

endmodule

// ===== rtl/core/multi_switch_debounce_fault_monitor.sv =====
// ----------------------------------------------------------------------------
// multi_switch_debounce_fault_monitor
// Debounces active-low hit switches, applies a global press lockout, marks
// stuck or chattering channels broken and reports accepted presses.
// ----------------------------------------------------------------------------
// The result of a sample is registered in the output register, or in the skid
// entry on a stall. Throughput: one sample per cycle while the skid entry is
// empty. A two-entry output stage keeps samples flowing while a result waits.
// Reset: synchronous; all channel state, the tick counter and the registers
// return to their reset values at once, no clearing pass.
// ----------------------------------------------------------------------------
module multi_switch_debounce_fault_monitor
   import mdfm_pkg::*;
#(
   parameter int CHANNELS  = CHANNELS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   mdfm_req_if.sink   req_if,
   mdfm_rsp_if.source rsp_if,
   mdfm_csr_if.sink   csr_if
);

   mdfm_cfg_type         cfg_ff;
   logic [TIME_BITS-1:0] tick_ff;
   logic                 step, armed;
   logic [CHANNELS-1:0]  press_req, grant;
   mdfm_lane_stat_type   stat [CHANNELS];
   mdfm_rsp_type         rsp_new;

   mdfm_rsp_type         out_ff, skid_ff;
   logic                 out_v_ff, skid_v_ff, out_free;

   // Register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle  <= SETTLE_RST;
         cfg_ff.lockout <= LOCKOUT_RST;
         cfg_ff.stuck   <= STUCK_RST;
         cfg_ff.window  <= WINDOW_RST;
         cfg_ff.limit   <= LIMIT_RST;
         cfg_ff.holdoff <= HOLDOFF_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_SETTLE:  cfg_ff.settle  <= csr_if.data[SETTLE_W-1:0];
            CSR_LOCKOUT: cfg_ff.lockout <= csr_if.data;
            CSR_STUCK:   cfg_ff.stuck   <= csr_if.data;
            CSR_WINDOW:  cfg_ff.window  <= csr_if.data;
            CSR_LIMIT:   cfg_ff.limit   <= csr_if.data[COUNT_W-1:0];
            CSR_HOLDOFF: cfg_ff.holdoff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Sample transfer and tick counter
   assign req_if.ready = !skid_v_ff;
   assign step         = req_if.valid && req_if.ready;
   assign armed        = tick_ff > {{(TIME_BITS-SPAN_W){1'b0}}, cfg_ff.holdoff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (step) begin
         tick_ff <= tick_ff + 1'b1;
      end
   end

   // Channel lanes
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic rd;
      if (i < PIN_W) begin : g_pin
         assign rd = req_if.pin_levels[i];
      end else begin : g_nopin
         assign rd = 1'b0;
      end

      mdfm_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .tick      (tick_ff),
         .armed     (armed),
         .cfg       (cfg_ff),
         .rd        (rd),
         .grant     (grant[i]),
         .press_req (press_req[i]),
         .stat      (stat[i])
      );
   end

   // Lockout priority and mask assembly
   mdfm_merge #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .tick      (tick_ff),
      .lockout   (cfg_ff.lockout),
      .press_req (press_req),
      .grant     (grant),
      .stat      (stat),
      .rsp       (rsp_new)
   );

   // Output register with skid entry
   assign out_free = !out_v_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (out_free) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= step;
            end
         end else if (step) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_v_ff) begin
            out_ff <= skid_ff;
         end else if (step) begin
            out_ff <= rsp_new;
         end
      end else if (step) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_if.valid        = out_v_ff;
   assign rsp_if.hit_mask     = out_ff.hit_mask;
   assign rsp_if.healthy_mask = out_ff.healthy_mask;
   assign rsp_if.pressed_mask = out_ff.pressed_mask;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the switch debounce and fault monitor. A directed
// table walks reset behavior, full-press, chatter, stuck and ignored register
// cases. Random phases follow, each with its own register setting, and drive
// press/release patterns with bounce and noise. Results of typed table rows
// are checked to their masks, the rest to a debounce, lockout and fault model.
// ----------------------------------------------------------------------------
module testbench;
   import mdfm_pkg::*;

   // Register indexes the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   localparam int NCH = CHANNELS_DEF;

   typedef logic [TIME_BITS_DEF-1:0] stamp_t;

   typedef enum logic {ROW_PINS, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e            kind;
      logic [PIN_W-1:0]     pins;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] data;
      bit                   typed;
      mdfm_rsp_type         want;
   } stim_row_t;

   typedef struct {
      logic [SETTLE_W-1:0] settle;
      logic [SPAN_W-1:0]   lockout;
      logic [SPAN_W-1:0]   stuck;
      logic [SPAN_W-1:0]   window;
      logic [COUNT_W-1:0]  limit;
      logic [SPAN_W-1:0]   holdoff;
      int                  items;
      int                  hold_max;
   } phase_t;

   logic clock;
   logic reset;

   mdfm_req_if req_ch ();
   mdfm_rsp_if rsp_ch ();
   mdfm_csr_if csr_ch ();

   multi_switch_debounce_fault_monitor uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Monitor model state
   // ------------------------------------------------------------------------
   mdfm_cfg_type      model_cfg;
   stamp_t            now_tick;
   stamp_t            last_accept;
   logic [NCH-1:0]    raw_prev;
   logic [NCH-1:0]    stable_lv;
   logic [NCH-1:0]    reported_lv;
   logic [NCH-1:0]    alive;
   stamp_t            toggle_at [NCH];
   stamp_t            window_at [NCH];
   stamp_t            press_at  [NCH];
   logic [COUNT_W-1:0] toggles  [NCH];

   mdfm_rsp_type due_masks [$];
   int           fail_count   = 0;
   int           results_seen = 0;
   bit           burst_mode   = 1'b0;
   bit           row_typed    = 1'b0;
   mdfm_rsp_type row_want     = '0;

   function automatic void reset_model();
      model_cfg   = '{settle: SETTLE_RST, lockout: LOCKOUT_RST, stuck: STUCK_RST,
                      window: WINDOW_RST, limit: LIMIT_RST, holdoff: HOLDOFF_RST};
      now_tick    = '0;
      last_accept = '0;
      raw_prev    = '1;
      stable_lv   = '1;
      reported_lv = '1;
      alive       = '1;
      for (int i = 0; i < NCH; i++) begin
         toggle_at[i] = '0;
         window_at[i] = '0;
         press_at[i]  = '0;
         toggles[i]   = '0;
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DAT_W-1:0] val);
      case (idx)
         CSR_SETTLE:  model_cfg.settle  = val[SETTLE_W-1:0];
         CSR_LOCKOUT: model_cfg.lockout = val[SPAN_W-1:0];
         CSR_STUCK:   model_cfg.stuck   = val[SPAN_W-1:0];
         CSR_WINDOW:  model_cfg.window  = val[SPAN_W-1:0];
         CSR_LIMIT:   model_cfg.limit   = val[COUNT_W-1:0];
         CSR_HOLDOFF: model_cfg.holdoff = val[SPAN_W-1:0];
         default: ;
      endcase
   endfunction

   // One tick of debounce, lockout, fault and hit logic; channel 0 goes first
   function automatic mdfm_rsp_type debounce_tick(input logic [PIN_W-1:0] pins);
      mdfm_rsp_type r;
      stamp_t       t;
      logic         rd;
      logic         armed;
      r     = '0;
      t     = now_tick;
      armed = t > stamp_t'(model_cfg.holdoff);
      for (int i = 0; i < NCH; i++) begin
         rd = pins[i];
         // raw edge: restart settle timer, count toggle
         if (rd != raw_prev[i] && alive[i]) begin
            toggle_at[i] = t;
            if (toggles[i] != TOGGLE_MAX)
               toggles[i] = toggles[i] + 1'b1;
            raw_prev[i] = rd;
         end
         // settled level change, presses gated by the global lockout
         if ((t - toggle_at[i]) > stamp_t'(model_cfg.settle) && alive[i] &&
             rd != stable_lv[i]) begin
            if (!rd) begin
               if ((t - last_accept) > stamp_t'(model_cfg.lockout)) begin
                  stable_lv[i] = 1'b0;
                  last_accept  = t;
                  press_at[i]  = t;
               end
            end else begin
               stable_lv[i] = 1'b1;
            end
         end
         // stuck low
         if (!stable_lv[i] && alive[i] &&
             (t - press_at[i]) > stamp_t'(model_cfg.stuck)) begin
            alive[i]     = 1'b0;
            stable_lv[i] = 1'b1;
         end
         // chatter window
         if (alive[i]) begin
            if ((t - window_at[i]) < stamp_t'(model_cfg.window)) begin
               if (toggles[i] > model_cfg.limit) begin
                  alive[i]     = 1'b0;
                  stable_lv[i] = 1'b1;
                  toggles[i]   = '0;
                  window_at[i] = t;
               end
            end else begin
               toggles[i]   = '0;
               window_at[i] = t;
            end
         end else begin
            toggles[i] = '0;
         end
         // hit reporting once armed
         if (armed && alive[i]) begin
            if (!stable_lv[i] && reported_lv[i]) begin
               r.hit_mask[i]  = 1'b1;
               reported_lv[i] = 1'b0;
            end else if (stable_lv[i] && !reported_lv[i]) begin
               reported_lv[i] = 1'b1;
            end
         end
         r.healthy_mask[i] = alive[i];
         r.pressed_mask[i] = !stable_lv[i];
      end
      now_tick = now_tick + 1'b1;
      return r;
   endfunction

   function automatic void check_mask(input string name, input logic [MASK_W-1:0] want,
                                      input logic [MASK_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Transfer monitor: register writes, sample prediction, result checks
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      mdfm_rsp_type predicted;
      mdfm_rsp_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            apply_csr(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            predicted = debounce_tick(req_ch.pin_levels);
            due_masks.push_back(row_typed ? row_want : predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (due_masks.size() == 0) begin
               $error("result transfer with nothing pending");
               fail_count++;
            end else begin
               want = due_masks.pop_front();
               check_mask("hit_mask", want.hit_mask, rsp_ch.hit_mask);
               check_mask("healthy_mask", want.healthy_mask, rsp_ch.healthy_mask);
               check_mask("pressed_mask", want.pressed_mask, rsp_ch.pressed_mask);
            end
         end
      end
   end

   // Mostly short gaps, a few long ones, none in burst stretches
   function automatic int pick_gap();
      int r;
      if (burst_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stalls plus one long hold-off to back up the block
   // ------------------------------------------------------------------------
   initial begin : receiver
      int  gap;
      bit  pressure_done;
      pressure_done = 1'b0;
      rsp_ch.ready  = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         @(negedge clock);
         if (!pressure_done && results_seen >= 300) begin
            rsp_ch.ready = 1'b0;
            repeat (80) @(negedge clock);
            pressure_done = 1'b1;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_pins(input logic [PIN_W-1:0] pins, input bit typed,
                            input mdfm_rsp_type want);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed         = typed;
      row_want          = want;
      req_ch.pin_levels = pins;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Register write once every pending result has come back
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (due_masks.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data  = val;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   stim_row_t rows [$];
   phase_t    phases [5];

   task automatic add_pins(input logic [PIN_W-1:0] pins, input bit typed,
                           input mdfm_rsp_type want);
      rows.push_back('{kind: ROW_PINS, pins: pins, index: CSR_SETTLE, data: '0,
                       typed: typed, want: want});
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      rows.push_back('{kind: ROW_CSR, pins: '1, index: idx, data: val,
                       typed: 1'b0, want: '0});
   endtask

   initial begin : stimulus
      logic [PIN_W-1:0] gen_level;
      int               gen_hold [NCH];
      logic [PIN_W-1:0] pins;
      int               w;

      req_ch.valid      = 1'b0;
      req_ch.pin_levels = '1;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_SETTLE;
      csr_ch.data       = '0;
      reset             = 1'b1;
      reset_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset state, all-pressed under the default lockout,
      // chatter kill on channel 9, ignored register indexes,
      // immediate hit with no holdoff, and a zero stuck limit
      add_pins(10'h3FF, 1'b1, {10'h000, 10'h3FF, 10'h000});
      add_pins(10'h000, 1'b1, {10'h000, 10'h3FF, 10'h000});
      add_pins(10'h000, 1'b1, {10'h000, 10'h3FF, 10'h000});
      add_pins(10'h000, 1'b1, {10'h000, 10'h3FF, 10'h000});
      add_pins(10'h3FF, 1'b0, '0);
      for (int k = 0; k < 9; k++)
         add_pins((k % 2 == 0) ? 10'h1FF : 10'h3FF, 1'b0, '0);
      add_csr(CSR_HOLDOFF, 16'd0);
      add_csr(CSR_LOCKOUT, 16'd0);
      add_csr(CSR_STUCK, 16'd0);
      add_csr(CSR_UNUSED_LO, 16'hFFFF);
      add_csr(CSR_UNUSED_HI, 16'h0000);
      add_pins(10'h2FF, 1'b0, '0);
      add_pins(10'h2FF, 1'b0, '0);
      add_pins(10'h2FF, 1'b1, {10'h100, 10'h1FF, 10'h100});
      add_pins(10'h2FF, 1'b1, {10'h000, 10'h0FF, 10'h000});

      foreach (rows[r]) begin
         if (rows[r].kind == ROW_CSR)
            write_csr(rows[r].index, rows[r].data);
         else
            send_pins(rows[r].pins, rows[r].typed, rows[r].want);
      end

      // Random phases; only the last one sets limits that break channels
      phases[0] = '{8'd1,   16'd0,     16'hFFFF, 16'hFFFF, 4'd15, 16'd0,     200, 8};
      phases[1] = '{8'd3,   16'd20,    16'hFFFF, 16'd0,    4'd0,  16'd0,     200, 12};
      phases[2] = '{8'd255, 16'd0,     16'hFFFF, 16'd100,  4'd15, 16'hFFFF,  300, 600};
      phases[3] = '{8'd2,   16'hFFFF,  16'hFFFF, 16'd30,   4'd15, 16'd0,     100, 10};
      phases[4] = '{8'd0,   16'd5,     16'd40,   16'd50,   4'd4,  16'd3,     150, 60};

      gen_level = '1;
      for (int i = 0; i < NCH; i++)
         gen_hold[i] = $urandom_range(0, 5);

      foreach (phases[p]) begin
         write_csr(CSR_SETTLE,  {8'($urandom), phases[p].settle});
         write_csr(CSR_LOCKOUT, phases[p].lockout);
         write_csr(CSR_STUCK,   phases[p].stuck);
         write_csr(CSR_WINDOW,  phases[p].window);
         write_csr(CSR_LIMIT,   {12'($urandom), phases[p].limit});
         write_csr(CSR_HOLDOFF, phases[p].holdoff);
         for (int n = 0; n < phases[p].items; n++) begin
            if (n % 64 == 0)
               burst_mode = ($urandom_range(0, 3) == 0);
            // per-channel press/release with short bounces
            for (int i = 0; i < NCH; i++) begin
               if (gen_hold[i] == 0) begin
                  gen_level[i] = !gen_level[i];
                  gen_hold[i]  = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 2)
                                 : $urandom_range(1, phases[p].hold_max);
               end else begin
                  gen_hold[i]--;
               end
            end
            pins = gen_level;
            if ($urandom_range(0, 19) == 0)
               pins = pins ^ PIN_W'($urandom_range(0, 1023));
            send_pins(pins, 1'b0, '0);
         end
      end

      // Drain
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_mode   = 1'b0;
      for (w = 0; w < 5000 && due_masks.size() != 0; w++)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (due_masks.size() != 0) begin
         $error("%0d results never arrived", due_masks.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
